/* hw/rtl/hfr_pkg.sv */
// ----------------------------------------------------------------------------
// hfr_pkg: shared types and constants of the face resampler
// Holds the store geometry, arithmetic widths, sequencer states and helpers.
// ----------------------------------------------------------------------------
package hfr_pkg;

  localparam int SRC_BITS     = 6;                    // column or row index
  localparam int SIZE_BITS    = 7;                    // size register width
  localparam int MAX_SIZE     = 1 << SRC_BITS;        // 64 pixels per edge
  localparam int STORE_DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_BITS    = 2 * SRC_BITS;
  localparam int CHAN_BITS    = 16;
  localparam int PIXEL_BITS   = 3 * CHAN_BITS;
  localparam int MAX_SAMPLES  = 256;
  localparam int CNT_BITS     = 9;                    // holds 0..MAX_SAMPLES
  localparam int SUM_BITS     = CHAN_BITS + 8;        // 256 samples of 16 bits
  localparam int RECIP_SHIFT  = 20;                   // reciprocal fraction bits
  localparam int RECIP_BITS   = RECIP_SHIFT + 1;
  localparam int SPAN_BITS    = 15;                   // N * target size
  localparam int MUL_A_BITS   = RECIP_BITS;
  localparam int MUL_B_BITS   = 13;
  localparam int PROD_BITS    = MUL_A_BITS + MUL_B_BITS;
  localparam int DIV_BITS     = SUM_BITS;
  localparam int DEN_BITS     = 9;
  localparam int DIV_STEPS    = DIV_BITS;
  localparam int DCNT_BITS    = 5;

  localparam logic [SIZE_BITS-1:0] SRC_RESET = 7'd64;
  localparam logic [SIZE_BITS-1:0] DST_RESET = 7'd32;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic CFG_SOURCE_SIZE = 1'b0;
  localparam logic CFG_TARGET_SIZE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECIP,
    ST_RATIO,
    ST_SQUARE,
    ST_SPAN,
    ST_COLX,
    ST_COLQ,
    ST_COLR,
    ST_REM,
    ST_ROWX,
    ST_PREP,
    ST_SAMPLE,
    ST_DIV_R,
    ST_DIV_G,
    ST_DIV_B,
    ST_OUT
  } state_t;

  // Radical inverse of an 8-bit sample index.
  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = b[7-k];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/hammersley_face_resampler.sv */
// ----------------------------------------------------------------------------
// hammersley_face_resampler: supersampled resize of one square RGB face
// Loads source pixels into an on-chip store and averages Hammersley samples.
// ----------------------------------------------------------------------------
// A load request (tuser low) writes one source pixel into the 4096-entry store.
// A compute request (tuser high) produces one averaged pixel, where
// N = min(256, (src/dst)^2) is the sample count. Once the request is accepted,
// the block takes the reciprocal of the target size on the shared divider,
// runs its setup on the shared multiplier, reads N samples from the store at
// one per cycle and drains the read pipeline, divides the three channel sums
// by N on the shared divider, and moves the pixel into the output register
// once that register is free. The next request can be accepted only after
// that, so compute requests do not overlap. The input is not ready while a
// compute request is in progress. The result sits in an output register, so
// the next request is taken while a finished pixel waits to be read. Entries
// of the store that were never loaded read back as undefined values.
module hammersley_face_resampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // col[5:0], row[11:6], red_in[27:12], green_in[43:28], blue_in[59:44]
  input  logic [63:0] in_tdata,
  // op[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red_out[15:0], green_out[31:16], blue_out[47:32]
  output logic [47:0] out_tdata
);
  import hfr_pkg::*;

  // Configuration registers.
  logic [SIZE_BITS-1:0] src_size_r, dst_size_r;
  logic [SIZE_BITS-1:0] src_eff, dst_eff;

  // Sequencer.
  state_t state_r, state_nxt;

  // Shared multiplier, its operands and its registered product.
  logic [MUL_A_BITS-1:0] mul_a;
  logic [MUL_B_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0]  prod_r;

  // Shared restoring divider.
  logic                  div_load;
  logic [DIV_BITS-1:0]   div_num;
  logic [DEN_BITS-1:0]   div_den;
  logic [DIV_BITS-1:0]   div_quo_r, div_quo_nxt;
  logic [DEN_BITS-1:0]   div_rem_r, div_rem_nxt;
  logic [DEN_BITS-1:0]   div_den_r, div_den_nxt;
  logic [DCNT_BITS-1:0]  div_cnt_r, div_cnt_nxt;
  logic [DEN_BITS:0]     div_trial;
  logic                  div_ge;
  logic                  div_done;

  // Setup values.
  logic [SRC_BITS-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic [RECIP_BITS-1:0] m_r, m_nxt;
  logic [CNT_BITS-1:0]   n_r, n_nxt;
  logic [SPAN_BITS-1:0]  d_r, d_nxt;
  logic [11:0]           xc_r, xc_nxt;
  logic [12:0]           u_r, u_nxt;
  logic [SPAN_BITS-1:0]  rem_r, rem_nxt;
  logic [11:0]           rowsrc_r, rowsrc_nxt;
  logic [SIZE_BITS-1:0]  ratio_raw, ratio;
  logic [12:0]           square;
  logic [CNT_BITS-1:0]   n_calc;
  logic [SIZE_BITS-1:0]  col_rem;

  // Sample pipeline.
  logic [CNT_BITS-1:0]   iss_r, iss_nxt;
  logic                  issue;
  logic                  va_r, vb_r, vc_r, vd_r;
  logic                  u_step;
  logic [SPAN_BITS-1:0]  rs;
  logic [SPAN_BITS:0]    rem_t;
  logic                  carry;
  logic [13:0]           hprod;
  logic [11:0]           xa_r, xa_nxt;
  logic [SRC_BITS-1:0]   ua_r, ua_nxt, ub_r, v_sat;
  logic [32:0]           pb_r;
  logic [12:0]           v_full;
  logic                  sample_done;

  // Source store.
  logic [PIXEL_BITS-1:0] store_mem [STORE_DEPTH];
  logic [PIXEL_BITS-1:0] rd_r;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  rd_addr;

  // Channel sums and quotients.
  logic [SUM_BITS-1:0]   sum_r_r, sum_g_r, sum_b_r;
  logic [SUM_BITS-1:0]   sum_r_nxt, sum_g_nxt, sum_b_nxt;
  logic [CHAN_BITS-1:0]  q_red_r, q_red_nxt, q_green_r, q_green_nxt;
  logic [CHAN_BITS-1:0]  q_blue_r, q_blue_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [PIXEL_BITS-1:0] out_data_r, out_data_nxt;
  logic                  out_load;

  logic in_fire;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A size of zero acts as one; an oversized source is clamped to the store.
  assign src_eff = (src_size_r == '0) ? 7'd1 :
                   (src_size_r > 7'(MAX_SIZE)) ? 7'(MAX_SIZE) : src_size_r;
  assign dst_eff = (dst_size_r == '0) ? 7'd1 : dst_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_size_r <= SRC_RESET;
      dst_size_r <= DST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOURCE_SIZE: src_size_r <= cfg_data;
        CFG_TARGET_SIZE: dst_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Divider: one quotient bit per cycle until all DIV_STEPS bits are formed,
  // and the quotient is taken once the step count reaches zero.
  // --------------------------------------------------------------------------
  assign div_trial = {div_rem_r, div_quo_r[DIV_BITS-1]};
  assign div_ge    = (div_trial >= {1'b0, div_den_r});
  assign div_done  = (div_cnt_r == '0);

  always_comb begin
    div_quo_nxt = div_quo_r;
    div_rem_nxt = div_rem_r;
    div_den_nxt = div_den_r;
    div_cnt_nxt = div_cnt_r;
    if (div_load) begin
      div_quo_nxt = div_num;
      div_rem_nxt = '0;
      div_den_nxt = div_den;
      div_cnt_nxt = DCNT_BITS'(DIV_STEPS);
    end else if (!div_done) begin
      div_rem_nxt = div_ge ? DEN_BITS'(div_trial - {1'b0, div_den_r})
                           : div_trial[DEN_BITS-1:0];
      div_quo_nxt = {div_quo_r[DIV_BITS-2:0], div_ge};
      div_cnt_nxt = div_cnt_r - 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Setup arithmetic seen by the sequencer.
  // --------------------------------------------------------------------------
  assign ratio_raw = prod_r[RECIP_SHIFT+SIZE_BITS-1:RECIP_SHIFT];
  assign ratio     = (ratio_raw == '0) ? 7'd1 : ratio_raw;
  assign square    = prod_r[12:0];
  assign n_calc    = (square > 13'(MAX_SAMPLES)) ? CNT_BITS'(MAX_SAMPLES)
                                                 : square[CNT_BITS-1:0];
  assign col_rem   = SIZE_BITS'(xc_r - prod_r[11:0]);

  // Per-sample column step: src = qs * D + rs with qs either zero or one.
  assign u_step = ({8'd0, src_eff} >= d_r);
  assign rs     = u_step ? ({8'd0, src_eff} - d_r) : {8'd0, src_eff};
  assign rem_t  = {1'b0, rem_r} + {1'b0, rs};
  assign carry  = (rem_t >= {1'b0, d_r});

  assign issue       = (iss_r < n_r);
  assign hprod       = 14'(rev8(iss_r[7:0])) * 14'(src_eff);
  assign sample_done = !issue && !va_r && !vb_r && !vc_r && !vd_r;
  assign v_full      = pb_r[32:RECIP_SHIFT];
  assign v_sat       = (v_full >= 13'(src_eff)) ? SRC_BITS'(src_eff - 1'b1)
                                                : v_full[SRC_BITS-1:0];
  assign rd_addr     = {v_sat, ub_r};
  assign wr_en       = in_fire && (in_tuser == OP_LOAD);

  // --------------------------------------------------------------------------
  // Next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire && (in_tuser == OP_COMPUTE)) state_nxt = ST_RECIP;
      ST_RECIP:  if (div_done) state_nxt = ST_RATIO;
      ST_RATIO:  state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_SPAN;
      ST_SPAN:   state_nxt = ST_COLX;
      ST_COLX:   state_nxt = ST_COLQ;
      ST_COLQ:   state_nxt = ST_COLR;
      ST_COLR:   state_nxt = ST_REM;
      ST_REM:    state_nxt = ST_ROWX;
      ST_ROWX:   state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_SAMPLE;
      ST_SAMPLE: if (sample_done) state_nxt = ST_DIV_R;
      ST_DIV_R:  if (div_done) state_nxt = ST_DIV_G;
      ST_DIV_G:  if (div_done) state_nxt = ST_DIV_B;
      ST_DIV_B:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: multiplier operands, divider loads, captures.
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    div_load    = 1'b0;
    div_num     = '0;
    div_den     = '0;
    col_nxt     = col_r;
    row_nxt     = row_r;
    m_nxt       = m_r;
    n_nxt       = n_r;
    d_nxt       = d_r;
    xc_nxt      = xc_r;
    u_nxt       = u_r;
    rem_nxt     = rem_r;
    rowsrc_nxt  = rowsrc_r;
    iss_nxt     = iss_r;
    xa_nxt      = xa_r;
    ua_nxt      = ua_r;
    sum_r_nxt   = sum_r_r;
    sum_g_nxt   = sum_g_r;
    sum_b_nxt   = sum_b_r;
    q_red_nxt   = q_red_r;
    q_green_nxt = q_green_r;
    q_blue_nxt  = q_blue_r;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == OP_COMPUTE)) begin
          col_nxt  = in_tdata[5:0];
          row_nxt  = in_tdata[11:6];
          // Ceiling reciprocal of the target size.
          div_load = 1'b1;
          div_num  = DIV_BITS'((1 << RECIP_SHIFT) + int'(dst_eff) - 1);
          div_den  = DEN_BITS'(dst_eff);
        end
      end
      ST_RECIP: begin
        if (div_done) m_nxt = div_quo_r[RECIP_BITS-1:0];
      end
      ST_RATIO: begin
        mul_a = m_r;
        mul_b = MUL_B_BITS'(src_eff);
      end
      ST_SQUARE: begin
        mul_a = MUL_A_BITS'(ratio);
        mul_b = MUL_B_BITS'(ratio);
      end
      ST_SPAN: begin
        n_nxt = n_calc;
        mul_a = MUL_A_BITS'(n_calc);
        mul_b = MUL_B_BITS'(dst_eff);
      end
      ST_COLX: begin
        d_nxt = prod_r[SPAN_BITS-1:0];
        mul_a = MUL_A_BITS'(col_r);
        mul_b = MUL_B_BITS'(src_eff);
      end
      ST_COLQ: begin
        xc_nxt = prod_r[11:0];
        mul_a  = m_r;
        mul_b  = MUL_B_BITS'(prod_r[11:0]);
      end
      ST_COLR: begin
        // First column sample is col * src / dst.
        u_nxt = prod_r[32:RECIP_SHIFT];
        mul_a = MUL_A_BITS'(prod_r[32:RECIP_SHIFT]);
        mul_b = MUL_B_BITS'(dst_eff);
      end
      ST_REM: begin
        mul_a = MUL_A_BITS'(col_rem);
        mul_b = MUL_B_BITS'(n_r);
      end
      ST_ROWX: begin
        rem_nxt = prod_r[SPAN_BITS-1:0];
        mul_a   = MUL_A_BITS'(row_r);
        mul_b   = MUL_B_BITS'(src_eff);
      end
      ST_PREP: begin
        rowsrc_nxt = prod_r[11:0];
        iss_nxt    = '0;
        sum_r_nxt  = '0;
        sum_g_nxt  = '0;
        sum_b_nxt  = '0;
      end
      ST_SAMPLE: begin
        if (issue) begin
          // Row sample: floor((row * src + rev8(i) * src / 256) / dst).
          xa_nxt  = rowsrc_r + 12'(hprod[13:8]);
          ua_nxt  = (u_r >= 13'(src_eff)) ? SRC_BITS'(src_eff - 1'b1)
                                          : u_r[SRC_BITS-1:0];
          rem_nxt = carry ? SPAN_BITS'(rem_t - {1'b0, d_r})
                          : rem_t[SPAN_BITS-1:0];
          u_nxt   = u_r + 13'(u_step) + 13'(carry);
          iss_nxt = iss_r + 1'b1;
        end
        // The store data of a sample is in rd_r while its vc_r flag is set.
        if (vc_r) begin
          sum_r_nxt = sum_r_r + SUM_BITS'(rd_r[CHAN_BITS-1:0]);
          sum_g_nxt = sum_g_r + SUM_BITS'(rd_r[2*CHAN_BITS-1:CHAN_BITS]);
          sum_b_nxt = sum_b_r + SUM_BITS'(rd_r[3*CHAN_BITS-1:2*CHAN_BITS]);
        end
        if (sample_done) begin
          div_load = 1'b1;
          div_num  = sum_r_r;
          div_den  = n_r;
        end
      end
      ST_DIV_R: begin
        if (div_done) begin
          q_red_nxt = div_quo_r[CHAN_BITS-1:0];
          div_load  = 1'b1;
          div_num   = sum_g_r;
          div_den   = n_r;
        end
      end
      ST_DIV_G: begin
        if (div_done) begin
          q_green_nxt = div_quo_r[CHAN_BITS-1:0];
          div_load    = 1'b1;
          div_num     = sum_b_r;
          div_den     = n_r;
        end
      end
      ST_DIV_B: begin
        if (div_done) q_blue_nxt = div_quo_r[CHAN_BITS-1:0];
      end
      ST_OUT: begin
        out_load = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign out_data_nxt  = out_load ? {q_blue_r, q_green_r, q_red_r} : out_data_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      va_r        <= (state_r == ST_SAMPLE) && issue;
      vb_r        <= va_r;
      vc_r        <= vb_r;
      vd_r        <= vc_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r     <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    div_quo_r  <= div_quo_nxt;
    div_rem_r  <= div_rem_nxt;
    div_den_r  <= div_den_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    m_r        <= m_nxt;
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    xc_r       <= xc_nxt;
    u_r        <= u_nxt;
    rem_r      <= rem_nxt;
    rowsrc_r   <= rowsrc_nxt;
    iss_r      <= iss_nxt;
    xa_r       <= xa_nxt;
    ua_r       <= ua_nxt;
    pb_r       <= 33'(xa_r) * 33'(m_r);
    ub_r       <= ua_r;
    sum_r_r    <= sum_r_nxt;
    sum_g_r    <= sum_g_nxt;
    sum_b_r    <= sum_b_nxt;
    q_red_r    <= q_red_nxt;
    q_green_r  <= q_green_nxt;
    q_blue_r   <= q_blue_nxt;
    out_data_r <= out_data_nxt;
  end

  // Source store: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[{in_tdata[11:6], in_tdata[5:0]}] <= in_tdata[59:12];
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= store_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_sample_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SAMPLE) && (state_nxt == ST_DIV_R) |-> (iss_r == n_r))
    else $error("sample loop ended before all samples were issued");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SAMPLE) |-> (rem_r < d_r))
    else $error("column remainder left its range");

  a_div_load: assert property (@(posedge clk) disable iff (!rst_n)
    div_load |=> (div_cnt_r == DCNT_BITS'(DIV_STEPS)))
    else $error("divider did not start a full division");

  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!va_r && !vb_r && !vc_r && !vd_r))
    else $error("request accepted while samples are still in flight");

endmodule
